[design/scpf_pkg.sv]
package scpf_pkg;

   // Type fields are four bits wide, so at most sixteen types take part.
   localparam int TYPE_W            = 4;
   localparam int MAX_TYPES         = 16;
   localparam int DEFAULT_NUM_TYPES = 16;

   // Distance lanes: five bits, all ones means not reached yet.
   localparam int               DIST_W    = 5;
   localparam logic [DIST_W-1:0] UNREACHED = 5'd31;

   // Stream widths.
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_FIND   = 1'b1
   } func_type;

   typedef enum logic [RSP_USER_W-1:0] {
      ST_ADDED  = 2'd0,
      ST_DUP    = 2'd1,
      ST_STEP   = 2'd2,
      ST_NOPATH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_INIT,
      S_SELECT,
      S_RELAX,
      S_WALK,
      S_EMIT,
      S_REPLY
   } state_type;

endpackage

[design/scpf_adj.sv]
module scpf_adj
   import scpf_pkg::*;
#(
   parameter int NUM_TYPES = DEFAULT_NUM_TYPES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [$clog2((NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES)-1:0] rd_row,
   input  logic                 wr_en,
   input  logic [$clog2((NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES)-1:0] wr_col,
   output logic [((NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES)-1:0]       rd_data
);

   localparam int ACTIVE = (NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES;

   logic [ACTIVE-1:0] adj_ff [ACTIVE];
   logic [ACTIVE-1:0] adj_in [ACTIVE];

   // Single read port; the write sets one bit in the row being read.
   assign rd_data = adj_ff[rd_row];

   always_comb begin
      adj_in = adj_ff;
      if (wr_en) begin
         adj_in[rd_row][wr_col] = 1'b1;
      end
   end

   // Clear every edge at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ACTIVE; r++) begin
            adj_ff[r] <= '0;
         end
      end else begin
         adj_ff <= adj_in;
      end
   end

endmodule

[design/shortest_conversion_path_finder.sv]
// Insert or refused query: the accepted beat passes through CHECK and REPLY into the output
// register, and the next beat is taken once the sequencer is back in IDLE. Query with a route:
// INIT, then SELECT and RELAX per vertex settled before the target, SELECT per level advance,
// then WALK back along predecessors and EMIT per path edge. Query without a route: INIT,
// SELECT and RELAX per settled vertex, SELECT per level advance, then REPLY. Result-side stalls
// hold REPLY and EMIT. req_tready is high only while idle; sync reset clears edges and valid.
module shortest_conversion_path_finder
   import scpf_pkg::*;
#(
   parameter int NUM_TYPES = DEFAULT_NUM_TYPES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] from_type, [7:4] to_type
   input  logic [0:0]            req_tuser,   // [0] func
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] step_from, [7:4] step_to
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] status
   output logic                  rsp_tlast
);

   localparam int ACTIVE = (NUM_TYPES < MAX_TYPES) ? NUM_TYPES : MAX_TYPES;
   localparam int VW     = $clog2(ACTIVE);

   // Sequencer and captured request
   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic [TYPE_W-1:0]  src_ff, src_in;
   logic [TYPE_W-1:0]  tgt_ff, tgt_in;
   status_type         res_ff, res_in;

   // Search state
   logic [DIST_W-1:0]  dist_ff [ACTIVE];
   logic [DIST_W-1:0]  dist_in [ACTIVE];
   logic [VW-1:0]      pred_ff [ACTIVE];
   logic [VW-1:0]      pred_in [ACTIVE];
   logic [VW-1:0]      chain_ff [ACTIVE];
   logic [VW-1:0]      chain_in [ACTIVE];
   logic [ACTIVE-1:0]  settled_ff, settled_in;
   logic [DIST_W-1:0]  level_ff, level_in;
   logic [VW-1:0]      u_ff, u_in;
   logic [VW-1:0]      idx_ff, idx_in;
   logic [VW-1:0]      len_ff, len_in;
   logic [VW-1:0]      cur_ff, cur_in;
   logic [VW-1:0]      prev_ff, prev_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [TYPE_W-1:0]  rsp_from_ff, rsp_from_in;
   logic [TYPE_W-1:0]  rsp_to_ff, rsp_to_in;
   logic               rsp_last_ff, rsp_last_in;

   // Shared unit signals
   logic [VW-1:0]      adj_row_sel;
   logic               adj_wr;
   logic [ACTIVE-1:0]  adj_row;
   logic [ACTIVE-1:0]  cand;
   logic [ACTIVE-1:0]  live;
   logic [ACTIVE-1:0]  relax_hit;
   logic [VW-1:0]      pick;
   logic [DIST_W-1:0]  level_next;
   logic               in_range;
   logic               out_free;
   logic [VW-1:0]      src_idx;
   logic [VW-1:0]      tgt_idx;

   assign src_idx    = src_ff[VW-1:0];
   assign tgt_idx    = tgt_ff[VW-1:0];
   assign in_range   = ({1'b0, src_ff} < (TYPE_W+1)'(ACTIVE)) &&
                       ({1'b0, tgt_ff} < (TYPE_W+1)'(ACTIVE));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign level_next = level_ff + DIST_W'(1);

   // Edge matrix: row is the source during a check, the settled vertex during relax
   assign adj_row_sel = (state_ff == S_RELAX) ? u_ff : src_idx;

   scpf_adj #(
      .NUM_TYPES (NUM_TYPES)
   ) u_adj (
      .clock   (clock),
      .reset   (reset),
      .rd_row  (adj_row_sel),
      .wr_en   (adj_wr),
      .wr_col  (tgt_idx),
      .rd_data (adj_row)
   );

   // Per-lane compares: candidates at the current level, live lanes, relax hits
   always_comb begin
      for (int v = 0; v < ACTIVE; v++) begin
         cand[v]      = !settled_ff[v] && (dist_ff[v] == level_ff);
         live[v]      = !settled_ff[v] && (dist_ff[v] != UNREACHED);
         relax_hit[v] = adj_row[v] && (level_next < dist_ff[v]);
      end
   end

   // Lowest-numbered candidate wins a tie
   always_comb begin
      pick = '0;
      for (int v = ACTIVE - 1; v >= 0; v--) begin
         if (cand[v]) begin
            pick = VW'(v);
         end
      end
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      src_in        = src_ff;
      tgt_in        = tgt_ff;
      res_in        = res_ff;
      dist_in       = dist_ff;
      pred_in       = pred_ff;
      chain_in      = chain_ff;
      settled_in    = settled_ff;
      level_in      = level_ff;
      u_in          = u_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;
      rsp_last_in   = rsp_last_ff;
      adj_wr        = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in  = func_type'(req_tuser[0]);
               src_in   = req_tdata[TYPE_W-1:0];
               tgt_in   = req_tdata[2*TYPE_W-1:TYPE_W];
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            state_in = S_REPLY;
            if (func_ff == FUNC_INSERT) begin
               if (!in_range || adj_row[tgt_idx]) begin
                  res_in = ST_DUP;
               end else begin
                  adj_wr = 1'b1;
                  res_in = ST_ADDED;
               end
            end else if (!in_range || (src_ff == tgt_ff)) begin
               res_in = ST_NOPATH;
            end else begin
               state_in = S_INIT;
            end
         end

         S_INIT: begin
            for (int v = 0; v < ACTIVE; v++) begin
               dist_in[v] = UNREACHED;
               pred_in[v] = '0;
            end
            dist_in[src_idx] = '0;
            settled_in       = '0;
            level_in         = '0;
            state_in         = S_SELECT;
         end

         S_SELECT: begin
            priority if (|cand) begin
               settled_in[pick] = 1'b1;
               u_in             = pick;
               if (pick == tgt_idx) begin
                  len_in                     = level_ff[VW-1:0];
                  idx_in                     = level_ff[VW-1:0];
                  cur_in                     = tgt_idx;
                  chain_in[level_ff[VW-1:0]] = tgt_idx;
                  state_in                   = S_WALK;
               end else begin
                  state_in = S_RELAX;
               end
            end else if (|live) begin
               level_in = level_next;
            end else begin
               res_in   = ST_NOPATH;
               state_in = S_REPLY;
            end
         end

         S_RELAX: begin
            for (int v = 0; v < ACTIVE; v++) begin
               if (relax_hit[v]) begin
                  dist_in[v] = level_next;
                  pred_in[v] = u_ff;
               end
            end
            state_in = S_SELECT;
         end

         S_WALK: begin
            // Follow predecessors back toward the source
            if (idx_ff == VW'(1)) begin
               idx_in   = VW'(1);
               prev_in  = src_idx;
               state_in = S_EMIT;
            end else begin
               chain_in[idx_ff - VW'(1)] = pred_ff[cur_ff];
               cur_in                    = pred_ff[cur_ff];
               idx_in                    = idx_ff - VW'(1);
            end
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_STEP;
               rsp_from_in   = TYPE_W'(prev_ff);
               rsp_to_in     = TYPE_W'(chain_ff[idx_ff]);
               rsp_last_in   = (idx_ff == len_ff);
               prev_in       = chain_ff[idx_ff];
               if (idx_ff == len_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + VW'(1);
               end
            end
         end

         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_ff;
               rsp_from_in   = '0;
               rsp_to_in     = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and search registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      src_ff        <= src_in;
      tgt_ff        <= tgt_in;
      res_ff        <= res_in;
      dist_ff       <= dist_in;
      pred_ff       <= pred_in;
      chain_ff      <= chain_in;
      settled_ff    <= settled_in;
      level_ff      <= level_in;
      u_ff          <= u_in;
      idx_ff        <= idx_in;
      len_ff        <= len_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      rsp_status_ff <= rsp_status_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_to_ff, rsp_from_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The source is settled before any deeper level is searched
   a_src_first: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SELECT && level_ff != '0) |-> settled_ff[src_idx])
      else $error("source not settled before level advance");

   // The walk starts only after the target is settled
   a_walk_tgt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> settled_ff[tgt_idx])
      else $error("path walk without settled target");

   // Emit index stays within the path
   a_emit_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (idx_ff != '0 && idx_ff <= len_ff))
      else $error("emit index out of path range");

   // Single-beat results carry zero steps and the last marker
   a_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_STEP) |->
         (rsp_last_ff && rsp_from_ff == '0 && rsp_to_ff == '0))
      else $error("non-path result malformed");

endmodule
